### src/svenv_pkg.sv
// Shared constants, types and the sine table builder for the sine voice with envelope.
`timescale 1ns / 1ps
package svenv_pkg;

  localparam int PHASE_BITS           = 32;
  localparam int SINE_TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS          = 16;

  localparam int FRAC      = SAMPLE_BITS - 1;
  localparam int ROM_N     = 1 << SINE_TABLE_ADDR_BITS;
  localparam int ROM_DEPTH = ROM_N + 1;
  localparam int ROM_AW    = SINE_TABLE_ADDR_BITS + 1;
  localparam int MAG_W     = SAMPLE_BITS;
  localparam int MUL_A_W   = SAMPLE_BITS + 16;
  localparam int MUL_B_W   = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SCALE_SHIFT = 30;
  localparam int OUT_MAG_W = PROD_W - SCALE_SHIFT;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_SOUND   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_FAST    = 2'd3;

  localparam logic [2:0] CFG_PHASE_STEP        = 3'd0;
  localparam logic [2:0] CFG_MAX_AMPLITUDE     = 3'd1;
  localparam logic [2:0] CFG_ATTACK_STEP       = 3'd2;
  localparam logic [2:0] CFG_RELEASE_STEP      = 3'd3;
  localparam logic [2:0] CFG_FAST_RELEASE_STEP = 3'd4;
  localparam logic [2:0] CFG_GLOBAL_VOLUME     = 3'd5;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_step;
    logic [15:0]           max_amplitude;
    logic [15:0]           attack_step;
    logic signed [15:0]    release_step;
    logic signed [15:0]    fast_release_step;
    logic [15:0]           global_volume;
  } cfg_t;

  typedef struct packed {
    logic              idle;
    logic              neg;
    logic [ROM_AW-1:0] rom_addr;
    logic [15:0]       amplitude;
    logic              ended;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQ1,
    BK_SQ2,
    BK_M5,
    BK_AMP,
    BK_VOL,
    BK_OUT
  } back_state_t;

  typedef logic [MAG_W-1:0] sine_rom_t [ROM_DEPTH];

  // Quarter-wave entry k: sin(k * pi/2 / ROM_N) by a truncated Taylor series in Q2.30.
  function automatic logic [MAG_W-1:0] sine_rom_value(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int n = 0; n < 0; n++) begin
    end
    x    = (HALF_PI_Q30 * 64'(k)) / ROM_N;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    return MAG_W'((sum + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC));
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      r[k] = sine_rom_value(k);
    end
    return r;
  endfunction

endpackage

### src/sine_voice_with_envelope_top.sv
// Top level of the sine voice with envelope: configuration registers, front end, queue, back end.
//
// Each input item is one sample tick carrying envelope_mode and note_start. It is
// taken at a rising edge where in_valid is high and in_stall is low. The front end
// updates amplitude and phase in the cycle of acceptance and queues the lookup in a
// two-entry queue, so in_stall rises only while that queue is full.
// The back end works one item at a time: a registered sine table read and five
// steps on a single shared multiplier (square, square, times magnitude, times
// amplitude, times volume), then rounding and saturation into the output register.
// The back end does not take the next item from the queue until the current result
// has been loaded into the output register.
// The result stays in the output register while out_stall is high; the back end
// then waits with the next result and the queue keeps taking ticks until it fills.
// Configuration writes use cfg_valid, cfg_ready, cfg_index and cfg_data; cfg_ready
// is always high and indexes beyond the register list are ignored.
// Reset clears phase, amplitude, the queue and the output valid, and loads the
// register defaults.
`timescale 1ns / 1ps
module sine_voice_with_envelope_top
  import svenv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         envelope_mode,
  input  logic               note_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample,
  output logic               note_ended,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  queue_valid;
  logic  queue_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step        <= '0;
      cfg.max_amplitude     <= 16'd32768;
      cfg.attack_step       <= 16'd1;
      cfg.release_step      <= -16'sd1;
      cfg.fast_release_step <= -16'sd8;
      cfg.global_volume     <= 16'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_STEP:        cfg.phase_step        <= PHASE_BITS'(cfg_data);
        CFG_MAX_AMPLITUDE:     cfg.max_amplitude     <= cfg_data[15:0];
        CFG_ATTACK_STEP:       cfg.attack_step       <= cfg_data[15:0];
        CFG_RELEASE_STEP:      cfg.release_step      <= signed'(cfg_data[15:0]);
        CFG_FAST_RELEASE_STEP: cfg.fast_release_step <= signed'(cfg_data[15:0]);
        CFG_GLOBAL_VOLUME:     cfg.global_volume     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  svenv_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .envelope_mode (envelope_mode),
    .note_start    (note_start),
    .cfg           (cfg),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  svenv_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (queue_valid),
    .full      (queue_full)
  );

  svenv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_valid   (queue_valid),
    .head          (head),
    .pop           (pop),
    .global_volume (cfg.global_volume),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample        (sample),
    .note_ended    (note_ended)
  );

endmodule

### src/svenv_fifo.sv
// Short item queue between the envelope front end and the waveform back end.
`timescale 1ns / 1ps
module svenv_fifo
  import svenv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  not_empty,
  output logic  full
);

  item_t              entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (FIFO_AW + 1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/svenv_front.sv
// Front end: accepts ticks, updates the envelope and phase, and queues the table lookup.
`timescale 1ns / 1ps
module svenv_front
  import svenv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] envelope_mode,
  input  logic       note_start,
  input  cfg_t       cfg,
  input  logic       queue_full,
  output logic       push,
  output item_t      push_item
);

  logic [PHASE_BITS-1:0] phase_acc;
  logic [15:0]           amplitude;
  logic [PHASE_BITS-1:0] base_phase;
  logic [15:0]           base_amp;
  logic [15:0]           amplitude_next;
  logic                  ended;
  logic [16:0]           attack_sum;
  logic signed [15:0]    rel_step;
  logic signed [17:0]    rel_sum;
  logic [1:0]            quad;
  logic [SINE_TABLE_ADDR_BITS-1:0] idx;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    base_phase     = note_start ? '0 : phase_acc;
    base_amp       = note_start ? '0 : amplitude;
    amplitude_next = base_amp;
    ended          = 1'b0;
    attack_sum     = {1'b0, base_amp} + {1'b0, cfg.attack_step};
    rel_step       = (envelope_mode == MODE_RELEASE) ? cfg.release_step
                                                     : cfg.fast_release_step;
    rel_sum        = signed'({2'b00, base_amp}) + 18'(rel_step);
    case (envelope_mode)
      MODE_IDLE: begin
        amplitude_next = base_amp;
      end
      MODE_SOUND: begin
        if (base_amp < cfg.max_amplitude) begin
          if (attack_sum > {1'b0, cfg.max_amplitude}) begin
            amplitude_next = cfg.max_amplitude;
          end else begin
            amplitude_next = attack_sum[15:0];
          end
        end
      end
      default: begin
        if (base_amp != '0) begin
          if (rel_sum < 0) begin
            amplitude_next = '0;
          end else if (rel_sum > 18'sd65535) begin
            amplitude_next = 16'hFFFF;
          end else begin
            amplitude_next = rel_sum[15:0];
          end
        end else begin
          ended = 1'b1;
        end
      end
    endcase
  end

  assign quad = base_phase[PHASE_BITS-1 -: 2];
  assign idx  = base_phase[PHASE_BITS-3 -: SINE_TABLE_ADDR_BITS];

  always_comb begin
    push_item.idle      = (envelope_mode == MODE_IDLE);
    push_item.neg       = quad[1];
    push_item.rom_addr  = quad[0] ? (ROM_AW'(ROM_N) - {1'b0, idx}) : {1'b0, idx};
    push_item.amplitude = amplitude_next;
    push_item.ended     = ended;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      amplitude <= '0;
    end else if (push) begin
      amplitude <= amplitude_next;
      if (envelope_mode == MODE_IDLE) begin
        phase_acc <= base_phase;
      end else begin
        phase_acc <= base_phase + cfg.phase_step;
      end
    end
  end

endmodule

### src/svenv_back.sv
// Back end: sine table read, fifth power, amplitude and volume scaling on one shared multiplier.
`timescale 1ns / 1ps
module svenv_back
  import svenv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               queue_valid,
  input  item_t              head,
  output logic               pop,
  input  logic [15:0]        global_volume,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample,
  output logic               note_ended
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  back_state_t state;
  back_state_t state_next;

  item_t                    cur;
  logic [MAG_W-1:0]         rom_q;
  logic [MAG_W-1:0]         m;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        prod_rnd;
  logic [MAG_W-1:0]         rnd;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic                     mul_en;
  logic                     out_load;
  logic [PROD_W-1:0]        scaled;
  logic [OUT_MAG_W-1:0]     mag;
  logic signed [SAMPLE_BITS-1:0] s_val;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (queue_valid) state_next = BK_SQ1;
      BK_SQ1:  state_next = BK_SQ2;
      BK_SQ2:  state_next = BK_M5;
      BK_M5:   state_next = BK_AMP;
      BK_AMP:  state_next = BK_VOL;
      BK_VOL:  state_next = BK_OUT;
      BK_OUT:  if (!out_valid || !out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  assign prod_rnd = prod + (PROD_W'(1) << (FRAC - 1));
  assign rnd      = MAG_W'(prod_rnd >> FRAC);

  always_comb begin
    pop      = 1'b0;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    out_load = 1'b0;
    case (state)
      BK_IDLE: begin
        pop = queue_valid;
      end
      BK_SQ1: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rom_q);
        mul_b  = MUL_B_W'(rom_q);
      end
      BK_SQ2: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rnd);
        mul_b  = MUL_B_W'(rnd);
      end
      BK_M5: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rnd);
        mul_b  = MUL_B_W'(m);
      end
      BK_AMP: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rnd);
        mul_b  = MUL_B_W'(cur.amplitude);
      end
      BK_VOL: begin
        mul_en = 1'b1;
        mul_a  = prod[MUL_A_W-1:0];
        mul_b  = MUL_B_W'(global_volume);
      end
      BK_OUT: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign scaled = prod + (PROD_W'(1) << (SCALE_SHIFT - 1));
  assign mag    = scaled[PROD_W-1:SCALE_SHIFT];

  always_comb begin
    if (cur.idle) begin
      s_val = '0;
    end else if (cur.neg) begin
      if (mag > (OUT_MAG_W'(1) << FRAC)) begin
        s_val = -(SAMPLE_BITS'(1) << FRAC);
      end else begin
        s_val = -signed'(SAMPLE_BITS'(mag));
      end
    end else begin
      if (mag > ((OUT_MAG_W'(1) << FRAC) - 1'b1)) begin
        s_val = signed'((SAMPLE_BITS'(1) << FRAC) - 1'b1);
      end else begin
        s_val = signed'(SAMPLE_BITS'(mag));
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[head.rom_addr];
    if (pop) begin
      cur <= head;
    end
    if (state == BK_SQ1) begin
      m <= rom_q;
    end
    if (mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (out_load) begin
      sample     <= 16'(s_val);
      note_ended <= cur.ended;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### tb/sv/tb_sine_voice_with_envelope_top.sv
// Testbench for the sine voice with envelope: envelope and sine^5 predictor, directed and random notes.
`timescale 1ns / 1ps
module tb_sine_voice_with_envelope_top;
  import svenv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [2:0]  CFG_UNUSED  = 3'd6;
  localparam int          PRINT_CAP   = 40;

  typedef struct packed {
    logic [15:0] sample;
    logic        ended;
  } voice_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         envelope_mode = MODE_IDLE;
  logic               note_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample;
  logic               note_ended;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = CFG_PHASE_STEP;
  logic [31:0]        cfg_data = '0;

  logic [15:0]   quarter_wave [0:1024];
  cfg_t          voice_cfg;
  logic [31:0]   voice_phase;
  int            voice_amp;
  voice_result_t expected_samples [$];

  int          mismatch_count = 0;
  int          results_seen = 0;
  int          ticks_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_len_req = 0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  sine_voice_with_envelope_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .envelope_mode (envelope_mode),
    .note_start    (note_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample        (sample),
    .note_ended    (note_ended),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] quarter_sine(int unsigned k);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    longint      acc;
    ang  = (64'd1686629713 * 64'(k)) / 64'd1024;
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 30)) begin
      acc = longint'(1) << 30;
    end
    return 16'((acc + (longint'(1) << 14)) >>> 15);
  endfunction

  function automatic logic [63:0] round_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'd16384) >> 15;
  endfunction

  // Envelope first, then sample from the current phase, then phase advance; idle: sample 0, phase held.
  task automatic advance_voice(input logic [1:0] mode, input logic start,
                               output voice_result_t r);
    logic [63:0] m;
    logic [63:0] m5;
    logic [63:0] mag;
    logic [1:0]  quad;
    logic [9:0]  idx;
    int          na;
    int          step;
    r.sample = '0;
    r.ended  = 1'b0;
    if (start) begin
      voice_phase = '0;
      voice_amp   = 0;
    end
    if (mode == MODE_IDLE) begin
      return;
    end
    if (mode == MODE_SOUND) begin
      if (voice_amp < int'(voice_cfg.max_amplitude)) begin
        na = voice_amp + int'(voice_cfg.attack_step);
        voice_amp = (na > int'(voice_cfg.max_amplitude)) ? int'(voice_cfg.max_amplitude) : na;
      end
    end else if (voice_amp != 0) begin
      step = (mode == MODE_RELEASE) ? int'($signed(voice_cfg.release_step))
                                    : int'($signed(voice_cfg.fast_release_step));
      na = voice_amp + step;
      if (na < 0) begin
        na = 0;
      end
      if (na > 65535) begin
        na = 65535;
      end
      voice_amp = na;
    end else begin
      r.ended = 1'b1;
    end
    quad = voice_phase[31:30];
    idx  = voice_phase[29:20];
    m    = quad[0] ? 64'(quarter_wave[1024 - int'(idx)]) : 64'(quarter_wave[idx]);
    m5   = round_mul(round_mul(round_mul(m, m), round_mul(m, m)), m);
    mag  = (m5 * 64'(voice_amp) * 64'(voice_cfg.global_volume) + (64'd1 << 29)) >> 30;
    if (quad[1]) begin
      if (mag > 64'd32768) begin
        mag = 64'd32768;
      end
      r.sample = 16'(64'd0 - mag);
    end else begin
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      r.sample = 16'(mag);
    end
    voice_phase = voice_phase + voice_cfg.phase_step;
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin
    voice_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
      end else begin
        want = expected_samples.pop_front();
        if (sample !== want.sample) begin
          report_mismatch($sformatf("result %0d sample %0d, expected %0d",
                                    results_seen, sample, $signed(want.sample)));
        end
        if (note_ended !== want.ended) begin
          report_mismatch($sformatf("result %0d note_ended %b, expected %b",
                                    results_seen, note_ended, want.ended));
        end
      end
      results_seen++;
    end
  end

  // Receiver: a requested long hold is counted here, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= hold_len_req;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sine_voice_with_envelope_top: mismatch");
      $finish;
    end
  end

  task automatic send_tick(input logic [1:0] mode, input logic start);
    voice_result_t r;
    in_valid      <= 1'b1;
    envelope_mode <= mode;
    note_start    <= start;
    do begin
      @(posedge clk);
    end while (in_stall);
    advance_voice(mode, start, r);
    expected_samples.push_back(r);
    ticks_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid      <= 1'b0;
      envelope_mode <= 2'($urandom);
      note_start    <= 1'($urandom);
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      CFG_PHASE_STEP:        voice_cfg.phase_step        = data;
      CFG_MAX_AMPLITUDE:     voice_cfg.max_amplitude     = data[15:0];
      CFG_ATTACK_STEP:       voice_cfg.attack_step       = data[15:0];
      CFG_RELEASE_STEP:      voice_cfg.release_step      = data[15:0];
      CFG_FAST_RELEASE_STEP: voice_cfg.fast_release_step = data[15:0];
      CFG_GLOBAL_VOLUME:     voice_cfg.global_volume     = data[15:0];
      default: ;
    endcase
  endtask

  // For the 16-bit registers the upper half of the data word carries junk, which they drop.
  task automatic load_settings(input cfg_t s);
    write_reg(CFG_PHASE_STEP, s.phase_step);
    write_reg(CFG_MAX_AMPLITUDE, {16'($urandom), s.max_amplitude});
    write_reg(CFG_ATTACK_STEP, {16'($urandom), s.attack_step});
    write_reg(CFG_RELEASE_STEP, {16'($urandom), s.release_step});
    write_reg(CFG_FAST_RELEASE_STEP, {16'($urandom), s.fast_release_step});
    write_reg(CFG_GLOBAL_VOLUME, {16'($urandom), s.global_volume});
    write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_samples.size() != 0);
  endtask

  function automatic cfg_t pick_settings();
    cfg_t s;
    case ($urandom_range(7))
      0: s.phase_step = 32'h0000_0000;
      1: s.phase_step = 32'h8000_0000;
      2: s.phase_step = 32'hFFFF_FFFF;
      3, 4: s.phase_step = $urandom;
      default: s.phase_step = $urandom_range(1, 32'h0400_0000);
    endcase
    case ($urandom_range(9))
      0: s.max_amplitude = 16'd0;
      1: s.max_amplitude = 16'hFFFF;
      2, 3: s.max_amplitude = 16'($urandom);
      default: s.max_amplitude = 16'd32768;
    endcase
    case ($urandom_range(9))
      0: s.attack_step = 16'd0;
      1: s.attack_step = 16'd32768;
      2: s.attack_step = 16'hFFFF;
      default: s.attack_step = 16'($urandom_range(512, 8192));
    endcase
    case ($urandom_range(9))
      0: s.release_step = 16'd0;
      1: s.release_step = 16'h8000;
      2: s.release_step = 16'($urandom_range(1, 32767));
      default: s.release_step = 16'(-int'($urandom_range(512, 8192)));
    endcase
    case ($urandom_range(9))
      0: s.fast_release_step = 16'd0;
      1: s.fast_release_step = 16'h8000;
      2: s.fast_release_step = 16'($urandom_range(1, 32767));
      default: s.fast_release_step = 16'(-int'($urandom_range(4096, 20000)));
    endcase
    case ($urandom_range(9))
      0: s.global_volume = 16'd0;
      1: s.global_volume = 16'hFFFF;
      2, 3: s.global_volume = 16'($urandom);
      default: s.global_volume = 16'd32768;
    endcase
    return s;
  endfunction

  // A note is a start, some sounding ticks with the odd idle one, then a release; else one random tick.
  task automatic play_note();
    logic [1:0] rel;
    if ($urandom_range(99) < 15) begin
      send_tick(2'($urandom), 1'($urandom));
      return;
    end
    send_tick(MODE_SOUND, 1'b1);
    repeat ($urandom_range(0, 24)) begin
      send_tick(($urandom_range(9) == 0) ? MODE_IDLE : MODE_SOUND, 1'b0);
    end
    rel = $urandom_range(1) ? MODE_RELEASE : MODE_FAST;
    repeat ($urandom_range(1, 40)) begin
      send_tick(rel, 1'b0);
    end
  endtask

  task automatic test_reset_state();
    send_tick(MODE_SOUND, 1'b1);
    send_tick(MODE_RELEASE, 1'b0);
    send_tick(MODE_RELEASE, 1'b0);
    send_tick(MODE_IDLE, 1'b0);
  endtask

  task automatic test_quadrant_peaks();
    cfg_t s;
    s.phase_step        = 32'h4000_0000;
    s.max_amplitude     = 16'd32768;
    s.attack_step       = 16'd32768;
    s.release_step      = 16'h8000;
    s.fast_release_step = 16'h8000;
    s.global_volume     = 16'd32768;
    wait_idle();
    load_settings(s);
    send_tick(MODE_SOUND, 1'b1);
    send_tick(MODE_SOUND, 1'b0);
    send_tick(MODE_SOUND, 1'b0);
    send_tick(MODE_SOUND, 1'b0);
    send_tick(MODE_FAST, 1'b0);
    send_tick(MODE_RELEASE, 1'b0);
    send_tick(MODE_IDLE, 1'b1);
  endtask

  task automatic test_clamps_and_odd_steps();
    cfg_t s;
    s.phase_step        = 32'h4010_0000;
    s.max_amplitude     = 16'hFFFF;
    s.attack_step       = 16'hFFFF;
    s.release_step      = 16'h7FFF;
    s.fast_release_step = 16'd0;
    s.global_volume     = 16'hFFFF;
    wait_idle();
    load_settings(s);
    send_tick(MODE_SOUND, 1'b1);
    send_tick(MODE_RELEASE, 1'b0);
    send_tick(MODE_FAST, 1'b0);
    send_tick(MODE_FAST, 1'b0);
    send_tick(MODE_SOUND, 1'b0);
    s.max_amplitude = 16'd1000;
    s.attack_step   = 16'd300;
    s.global_volume = 16'd32768;
    wait_idle();
    load_settings(s);
    send_tick(MODE_SOUND, 1'b0);
    send_tick(MODE_SOUND, 1'b1);
    repeat (3) send_tick(MODE_SOUND, 1'b0);
  endtask

  task automatic test_backpressure();
    cfg_t s;
    s = pick_settings();
    s.phase_step = 32'h0123_4567;
    wait_idle();
    load_settings(s);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_len_req  <= 300;
    hold_token    <= hold_token + 1;
    repeat (2) play_note();
    while (ticks_sent < 90) begin
      send_tick(MODE_SOUND, 1'b0);
    end
  endtask

  task automatic test_random_notes(input int send_pct, input int recv_pct);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    repeat (3) begin
      wait_idle();
      load_settings(pick_settings());
      target = ticks_sent + 150;
      while (ticks_sent < target) begin
        play_note();
      end
    end
  endtask

  initial begin
    for (int k = 0; k <= 1024; k++) begin
      quarter_wave[k] = quarter_sine(k);
    end
    voice_cfg.phase_step        = '0;
    voice_cfg.max_amplitude     = 16'd32768;
    voice_cfg.attack_step       = 16'd1;
    voice_cfg.release_step      = 16'hFFFF;
    voice_cfg.fast_release_step = 16'hFFF8;
    voice_cfg.global_volume     = 16'd32768;
    voice_phase = '0;
    voice_amp   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_quadrant_peaks();
    test_clamps_and_odd_steps();
    test_backpressure();
    test_random_notes(38, 60);
    test_random_notes(60, 38);
    test_random_notes(0, 0);
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sine_voice_with_envelope_top: match");
    end else begin
      $display("sine_voice_with_envelope_top: mismatch");
    end
    $finish;
  end

endmodule

### sine_voice_with_envelope_top.f
src/svenv_pkg.sv
src/svenv_fifo.sv
src/svenv_front.sv
src/svenv_back.sv
src/sine_voice_with_envelope_top.sv
tb/sv/tb_sine_voice_with_envelope_top.sv
